// ===== design/binary_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the binary_to_decimal_ascii RTL.
// Needs no other file; define ASSERT_OFF to compile the checks away.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk_i and idle during reset.
`define B2DASC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("binary_to_decimal_ascii check failed");

// Next-cycle implication, sampled on clk_i and idle during reset.
`define B2DASC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("binary_to_decimal_ascii check failed");

`else

`define B2DASC_ASSERT_IMP(lbl, ante, cons)
`define B2DASC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/b2dasc_pkg.sv =====
// Types and constants for the binary_to_decimal_ascii block.
// Self-contained; used by binary_to_decimal_ascii.
package b2dasc_pkg;

  // Number of decimal places of a 16-bit unsigned value.
  localparam int unsigned NumPlaces = 5;

  localparam int unsigned ValueW = 16;
  localparam int unsigned CharW  = 6;
  localparam int unsigned CountW = 3;   // holds 0..NumPlaces
  localparam int unsigned RecipW = 32;

  typedef logic [3:0]        digit_t;
  typedef logic [ValueW-1:0] value_t;
  typedef logic [CharW-1:0]  char_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [RecipW-1:0] recip_t;

  // ASCII code of the character '0'.
  localparam char_t DigitBase = 6'h30;

  // Rounded-up reciprocals 2^32 / 10^k for k = 1..4. For any 16-bit value
  // the error of (v * recip) >> 32 stays far below one unit, so the floor
  // is exact.
  localparam recip_t Recip10    = 32'd429496730;
  localparam recip_t Recip100   = 32'd42949673;
  localparam recip_t Recip1000  = 32'd4294968;
  localparam recip_t Recip10000 = 32'd429497;

endpackage

// ===== design/binary_to_decimal_ascii.sv =====
// An accepted item waits in the input register, moves into the serializer when that is free,
// and leaves through the result register. Throughput: one character per cycle while the
// serializer holds digits; an item has 1..5 digits, and the next one loads as the last leaves.
// The receiver cannot stall; busy is high while an item waits in the input register and the serializer is not free.
// Reset (rst_ni low, asynchronous) empties the input register and the serializer.
// Depends on b2dasc_pkg and binary_to_decimal_ascii_macros.svh.
`include "binary_to_decimal_ascii_macros.svh"

module binary_to_decimal_ascii (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [b2dasc_pkg::ValueW-1:0] value_i,
  output logic                         strobe_o,
  output logic [b2dasc_pkg::CharW-1:0] digit_char_o,
  output logic                         last_char_o
);

  // Input register.
  logic               in_vld_q, in_vld_d;
  b2dasc_pkg::value_t value_q;

  // Serializer: digits waiting to leave, most significant in slot 0.
  b2dasc_pkg::digit_t buf_q [b2dasc_pkg::NumPlaces];
  b2dasc_pkg::digit_t buf_d [b2dasc_pkg::NumPlaces];
  b2dasc_pkg::count_t cnt_q, cnt_d;

  // Result register.
  logic              strobe_q;
  b2dasc_pkg::char_t char_q;
  logic              last_q;

  logic accept;
  logic emit;
  logic ser_free;
  logic load;

  // Quotients v / 10^k, digits and digit count of the waiting item.
  b2dasc_pkg::value_t quot  [b2dasc_pkg::NumPlaces];
  b2dasc_pkg::digit_t digit [b2dasc_pkg::NumPlaces];
  b2dasc_pkg::count_t ndig;
  logic [47:0]        prod  [1:b2dasc_pkg::NumPlaces-1];

  // Handshake: the input register is busy when its item cannot move on.
  assign emit     = (cnt_q != '0);
  assign ser_free = (cnt_q <= b2dasc_pkg::count_t'(1));
  assign load     = in_vld_q && ser_free;
  assign busy     = in_vld_q && !ser_free;
  assign accept   = start && !busy;

  // Quotients by reciprocal multiplication; each one is independent.
  always_comb begin
    prod[1] = {32'd0, value_q} * {16'd0, b2dasc_pkg::Recip10};
    prod[2] = {32'd0, value_q} * {16'd0, b2dasc_pkg::Recip100};
    prod[3] = {32'd0, value_q} * {16'd0, b2dasc_pkg::Recip1000};
    prod[4] = {32'd0, value_q} * {16'd0, b2dasc_pkg::Recip10000};
    quot[0] = value_q;
    for (int k = 1; k < b2dasc_pkg::NumPlaces; k++) begin
      quot[k] = prod[k][47:32];
    end
  end

  // Each digit is one quotient less ten times the next; index 0 is the units.
  always_comb begin
    for (int k = 0; k < b2dasc_pkg::NumPlaces - 1; k++) begin
      digit[k] = b2dasc_pkg::digit_t'(quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1)));
    end
    digit[b2dasc_pkg::NumPlaces-1] = quot[b2dasc_pkg::NumPlaces-1][3:0];
  end

  // Digit count: the highest nonzero place, and never less than one.
  always_comb begin
    if (quot[4] != '0) begin
      ndig = b2dasc_pkg::count_t'(5);
    end else if (quot[3] != '0) begin
      ndig = b2dasc_pkg::count_t'(4);
    end else if (quot[2] != '0) begin
      ndig = b2dasc_pkg::count_t'(3);
    end else if (quot[1] != '0) begin
      ndig = b2dasc_pkg::count_t'(2);
    end else begin
      ndig = b2dasc_pkg::count_t'(1);
    end
  end

  // Serializer next state: load a new item, or shift out one digit.
  always_comb begin
    for (int i = 0; i < b2dasc_pkg::NumPlaces; i++) begin
      buf_d[i] = buf_q[i];
    end
    cnt_d = cnt_q;
    if (load) begin
      // Slot i holds the digit of place ndig-1-i, so slot 0 is the leading digit.
      for (int i = 0; i < b2dasc_pkg::NumPlaces; i++) begin
        if (i < int'(ndig)) begin
          buf_d[i] = digit[int'(ndig) - 1 - i];
        end else begin
          buf_d[i] = '0;
        end
      end
      cnt_d = ndig;
    end else if (emit) begin
      for (int i = 0; i < b2dasc_pkg::NumPlaces - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_d[b2dasc_pkg::NumPlaces-1] = '0;
      cnt_d = cnt_q - b2dasc_pkg::count_t'(1);
    end
  end

  // Input register valid flag.
  always_comb begin
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (load) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      cnt_q    <= cnt_d;
      strobe_q <= emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
    end
    for (int i = 0; i < b2dasc_pkg::NumPlaces; i++) begin
      buf_q[i] <= buf_d[i];
    end
    char_q <= b2dasc_pkg::DigitBase + b2dasc_pkg::char_t'(buf_q[0]);
    last_q <= (cnt_q == b2dasc_pkg::count_t'(1));
  end

  assign strobe_o     = strobe_q;
  assign digit_char_o = char_q;
  assign last_char_o  = last_q;

  // Checks on the internal flow.
  `B2DASC_ASSERT_IMP(a_busy_needs_item, busy, in_vld_q)
  `B2DASC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= b2dasc_pkg::count_t'(b2dasc_pkg::NumPlaces))
  `B2DASC_ASSERT_NXT(a_accept_holds, accept, in_vld_q)
  `B2DASC_ASSERT_NXT(a_load_emits, load, emit)
  `B2DASC_ASSERT_NXT(a_run_unbroken, strobe_q && !last_q, strobe_q)

endmodule

// ===== tb/sv/binary_to_decimal_ascii_test.sv =====
// Self-checking testbench for binary_to_decimal_ascii: feeds 16-bit values and
// checks every decimal ASCII character and its last flag against a local predictor.
// Depends on b2dasc_pkg and the binary_to_decimal_ascii RTL.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;

  localparam int unsigned DirCount   = 20;
  localparam int unsigned RandCount  = 250;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainWait  = 12;  // extra wait after the final drain

  // One expected character of a decimal run.
  typedef struct packed {
    b2dasc_pkg::char_t ch;
    logic              last;
  } text_char_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  b2dasc_pkg::value_t value_i;
  logic               strobe_o;
  b2dasc_pkg::char_t  digit_char_o;
  logic               last_char_o;

  text_char_t  char_q[$];       // characters still to come, oldest first
  string       item_text_q[$];  // typed text per item in flight, empty means predicted
  int unsigned errors;
  int unsigned items_taken;
  int unsigned chars_seen;
  int unsigned cycles;

  // Directed values; the text is filled in only where it is obvious.
  b2dasc_pkg::value_t dir_value [DirCount] = '{
    16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd9999, 16'd10000, 16'd65535,
    16'd10001, 16'd10203, 16'd50400, 16'd32768, 16'd21845, 16'd43690, 16'd1024,
    16'd909, 16'd255, 16'd4096, 16'd60006
  };
  string dir_text [DirCount] = '{
    "0", "1", "9", "10", "99", "100", "9999", "10000", "65535",
    "", "", "", "", "", "", "", "", "", "", ""
  };

  binary_to_decimal_ascii dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_char_o  (last_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Queues the decimal characters of a value, leading zeros dropped.
  function automatic void predict_decimal(input b2dasc_pkg::value_t v);
    int unsigned rest;
    int unsigned place;
    int unsigned q;
    bit          started;
    text_char_t  c;
    rest    = v;
    place   = 10000;
    started = 1'b0;
    while (place > 0) begin
      q = rest / place;
      if (q != 0 || started || place == 1) begin
        rest    = rest - q * place;
        started = 1'b1;
        c.ch    = b2dasc_pkg::DigitBase + b2dasc_pkg::char_t'(q);
        c.last  = (place == 1);
        char_q.push_back(c);
      end
      place = place / 10;
    end
  endfunction

  // Queues the characters of a typed string; the final one carries the flag.
  function automatic void queue_typed_text(input string txt);
    text_char_t c;
    for (int i = 0; i < txt.len(); i++) begin
      c.ch   = b2dasc_pkg::char_t'(txt[i]);
      c.last = (i == txt.len() - 1);
      char_q.push_back(c);
    end
  endfunction

  // Random value: mostly a chosen digit count, some full range, some sparse digits.
  function automatic b2dasc_pkg::value_t pick_value();
    int unsigned mode;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    mode = $urandom_range(0, 7);
    n    = $urandom_range(1, 5);
    lo   = (n == 1) ? 0 : 10 ** (n - 1);
    hi   = (n == 5) ? 65535 : 10 ** n - 1;
    if (mode < 2) begin
      v = $urandom_range(0, 65535);
    end else if (mode < 4) begin
      // Leading digit nonzero, lower digits zero half the time.
      v = $urandom_range(1, 9);
      for (int k = 1; k < n; k++) begin
        v = v * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
      end
      v = v % 65536;
    end else begin
      v = $urandom_range(hi, lo);
    end
    return b2dasc_pkg::value_t'(v);
  endfunction

  // Drives one item and returns at the edge that accepts it.
  task automatic send_value(input b2dasc_pkg::value_t v, input string txt);
    item_text_q.push_back(txt);
    start   <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Lowers start for a random gap, in about a quarter of the items.
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every queued character has come out.
  task automatic drain_chars();
    start <= 1'b0;
    do @(posedge clk_i); while (char_q.size() != 0);
  endtask

  // Checks each character strobe and records the expectation of each accepted item.
  always @(posedge clk_i) begin : track_chars
    text_char_t e;
    string      txt;
    if (rst_ni) begin
      if (strobe_o) begin
        chars_seen++;
        if (char_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected character: expected none, actual %0d last %0b",
                   $time, digit_char_o, last_char_o);
        end else begin
          e = char_q.pop_front();
          if (digit_char_o !== e.ch) begin
            errors++;
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, e.ch, digit_char_o);
          end
          if (last_char_o !== e.last) begin
            errors++;
            $display("%0t: last_char mismatch: expected %0b, actual %0b",
                     $time, e.last, last_char_o);
          end
        end
      end
      if (start && !busy) begin
        items_taken++;
        txt = (item_text_q.size() != 0) ? item_text_q.pop_front() : "";
        if (txt.len() != 0) begin
          queue_typed_text(txt);
        end else begin
          predict_decimal(value_i);
        end
      end
    end
  end

  // Guards against a hang.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d characters outstanding", $time, char_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reset, directed table, random values, then drain and report.
  initial begin
    errors      = 0;
    items_taken = 0;
    chars_seen  = 0;
    cycles      = 0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    value_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      send_value(dir_value[i], dir_text[i]);
      maybe_idle(1'b1);
    end
    drain_chars();

    // Items 80 to 149 go back to back.
    for (int i = 0; i < RandCount; i++) begin
      send_value(pick_value(), "");
      if (i == 200) begin
        drain_chars();
      end else begin
        maybe_idle(!(i >= 80 && i < 150));
      end
    end
    drain_chars();
    repeat (DrainWait) @(posedge clk_i);

    if (char_q.size() != 0) begin
      errors += char_q.size();
      $display("%0t: %0d expected characters never arrived", $time, char_q.size());
    end
    $display("Converted %0d values into %0d characters: digit-count extremes,", items_taken,
             chars_seen);
    $display("interior zeros and random values of one to five digits, with and without gaps.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/b2dasc_pkg.sv
design/binary_to_decimal_ascii.sv
tb/sv/binary_to_decimal_ascii_test.sv
